>>> rtl/hav_pkg.sv
// Package: constants, field widths and CORDIC arctangent table for the haversine block.
`default_nettype none

package hav_pkg;

    // Field widths
    localparam int LAT_W       = 31;
    localparam int LON_W       = 32;
    localparam int DIST_W      = 31;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 32;

    // One full turn in units of 1e-7 degree
    localparam logic signed [34:0] DEG7_TURN  = 35'sd3600000000;
    // 2^63 / 3.6e9, rounded: turns 1e-7 degree into binary phase
    localparam logic [31:0]        PHASE_K    = 32'd2562047788;
    // CORDIC gain compensation, Q30
    localparam logic signed [32:0] CORDIC_X0  = 33'sd652032874;
    localparam logic [30:0]        Q30_ONE    = 31'h4000_0000;
    localparam logic [60:0]        Q60_ONE    = 61'h1000_0000_0000_0000;
    // round(637813700 * 4 * pi)
    localparam logic [32:0]        DIST_SCALE = 33'd8015003337;
    // Half circumference in cm
    localparam logic [30:0]        DIST_MAX   = 31'd2003750834;

    // atan(2^-i) as a phase, 2^32 per turn
    localparam logic [31:0] ATAN_PHASE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

`default_nettype wire

>>> rtl/haversine_distance.sv
// Top level: pipelined fixed-point haversine great-circle distance.
`default_nettype none

// Channel  | Dir | Signals                          | Payload (low bit first)
// ---------+-----+----------------------------------+--------------------------------------
// s_axis   | in  | tvalid / tready / tdata[127:0]   | start_lat[30:0] start_lon[62:31]
//          |     |                                  | end_lat[93:63] end_lon[125:94], 0 pad
// m_axis   | out | tvalid / tready / tdata[31:0]    | distance_cm[30:0], 0 pad
//
// One transaction per cycle while the output is not stalled.
// The pipeline depth is set by the two unrolled CORDIC chains (rotation for sin/cos,
// vectoring for atan2) and the 31-stage bitwise square root.
// Reset (i_rst_n low, synchronous) clears the pipe, output and skid valid bits, not the data.
// A downstream stall parks one result in the skid register; the whole pipe then
// holds and s_axis tready drops until the skid drains.

module haversine_distance #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // start_lat[30:0], start_lon[62:31], end_lat[93:63], end_lon[125:94]
    input  wire logic [hav_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // distance_cm[30:0]
    output logic [hav_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import hav_pkg::*;

    localparam int NS    = CORDIC_STEPS;
    localparam int XW    = 33;          // CORDIC x/y width
    localparam int ZW    = 34;          // CORDIC angle width
    localparam int QW    = 62;          // square root work width
    localparam int QN    = 31;          // square root steps (bits 2^60 .. 2^0)
    localparam int DEPTH = 2 * NS + 42;

    // ---------------- flow control ----------------
    logic             ce;
    logic             s_acc;
    logic [DEPTH-1:0] r_vld;
    logic             r_out_v;
    logic             r_sk_v;
    logic [DIST_W-1:0] r_out_d;
    logic [DIST_W-1:0] r_sk_d;
    logic [DIST_W-1:0] p_dist;
    logic             pv;

    assign ce              = !r_sk_v;
    assign o_s_axis_tready = ce;
    assign s_acc           = i_s_axis_tvalid && ce;
    assign pv              = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[DEPTH-2:0], s_acc};
        end
    end

    // ---------------- stage 1: differences ----------------
    logic signed [LAT_W-1:0] in_lat1, in_lat2;
    logic signed [LON_W-1:0] in_lon1, in_lon2;
    logic signed [LAT_W-1:0] r_a_lat1, r_a_lat2;
    logic signed [LAT_W:0]   r_a_dlat;
    logic signed [LON_W:0]   r_a_dlon;

    assign in_lat1 = i_s_axis_tdata[30:0];
    assign in_lon1 = i_s_axis_tdata[62:31];
    assign in_lat2 = i_s_axis_tdata[93:63];
    assign in_lon2 = i_s_axis_tdata[125:94];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a_lat1 <= in_lat1;
            r_a_lat2 <= in_lat2;
            r_a_dlat <= (LAT_W+1)'(in_lat2) - (LAT_W+1)'(in_lat1);
            r_a_dlon <= (LON_W+1)'(in_lon2) - (LON_W+1)'(in_lon1);
        end
    end

    // ---------------- stage 2: reduce modulo one turn ----------------
    function automatic logic [31:0] wrap_turn(input logic signed [34:0] a);
        logic signed [34:0] r;
        if (a < 0) begin
            r = a + DEG7_TURN;
            if (r < 0) begin
                r = r + DEG7_TURN;
            end
        end else if (a >= DEG7_TURN) begin
            r = a - DEG7_TURN;
        end else begin
            r = a;
        end
        return r[31:0];
    endfunction

    // lanes: 0 dlat (half), 1 dlon (half), 2 lat1 (full), 3 lat2 (full)
    logic [31:0] r_w [4];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_w[0] <= wrap_turn(35'(r_a_dlat));
            r_w[1] <= wrap_turn(35'(r_a_dlon));
            r_w[2] <= wrap_turn(35'(r_a_lat1));
            r_w[3] <= wrap_turn(35'(r_a_lat2));
        end
    end

    // ---------------- stage 3: phase multiply ----------------
    logic [63:0] r_p [4];

    // ---------------- rotation CORDIC arrays ----------------
    logic signed [XW-1:0] r_rx   [4][NS+1];
    logic signed [XW-1:0] r_ry   [4][NS+1];
    logic signed [ZW-1:0] r_rz   [4][NS+1];
    logic                 r_flip [4][NS+1];

    genvar l, j;
    generate
        for (l = 0; l < 4; l++) begin : g_lane
            logic [63:0] ph_sum;
            logic [31:0] ph;
            logic signed [ZW-1:0] zf;

            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_p[l] <= 64'(r_w[l]) * 64'(PHASE_K);
                end
            end

            // half phase for the differences, full phase for the latitudes
            if (l < 2) begin : g_half
                assign ph_sum = r_p[l] + 64'h8000_0000;
                assign ph     = ph_sum[63:32];
            end else begin : g_full
                assign ph_sum = r_p[l] + 64'h4000_0000;
                assign ph     = ph_sum[62:31];
            end
            assign zf = $signed({2'b00, ph});

            // fold into [-quarter, quarter), remember the half-turn flip
            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_rx[l][0] <= CORDIC_X0;
                    r_ry[l][0] <= '0;
                    if (ph >= 32'h4000_0000 && ph < 32'hC000_0000) begin
                        r_rz[l][0]   <= zf - 34'sd2147483648;
                        r_flip[l][0] <= 1'b1;
                    end else if (ph >= 32'hC000_0000) begin
                        r_rz[l][0]   <= zf - 34'sd4294967296;
                        r_flip[l][0] <= 1'b0;
                    end else begin
                        r_rz[l][0]   <= zf;
                        r_flip[l][0] <= 1'b0;
                    end
                end
            end

            for (j = 0; j < NS; j++) begin : g_rot
                logic signed [XW-1:0] xs, ys;
                logic signed [ZW-1:0] at;
                assign xs = r_rx[l][j] >>> j;
                assign ys = r_ry[l][j] >>> j;
                assign at = $signed({2'b00, ATAN_PHASE[j]});
                always_ff @(posedge i_clk) begin
                    if (ce) begin
                        r_flip[l][j+1] <= r_flip[l][j];
                        if (!r_rz[l][j][ZW-1]) begin
                            r_rx[l][j+1] <= r_rx[l][j] - ys;
                            r_ry[l][j+1] <= r_ry[l][j] + xs;
                            r_rz[l][j+1] <= r_rz[l][j] - at;
                        end else begin
                            r_rx[l][j+1] <= r_rx[l][j] + ys;
                            r_ry[l][j+1] <= r_ry[l][j] - xs;
                            r_rz[l][j+1] <= r_rz[l][j] + at;
                        end
                    end
                end
            end
        end
    endgenerate

    // ---------------- apply flip: sin of half differences, cos of latitudes ----
    logic signed [XW-1:0] r_slat, r_slon, r_cs1, r_cs2;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_slat <= r_flip[0][NS] ? -r_ry[0][NS] : r_ry[0][NS];
            r_slon <= r_flip[1][NS] ? -r_ry[1][NS] : r_ry[1][NS];
            r_cs1  <= r_flip[2][NS] ? -r_rx[2][NS] : r_rx[2][NS];
            r_cs2  <= r_flip[3][NS] ? -r_rx[3][NS] : r_rx[3][NS];
        end
    end

    // ---------------- products ----------------
    logic signed [65:0] r_c12p, r_ma_sq, r_mb_sq, r_mc_sq;
    logic signed [XW-1:0] r_ma_slon, r_mb_slon;
    logic signed [66:0] r_tp, r_ts;
    logic signed [33:0] c12, tq;

    assign c12 = r_c12p[63:30];
    assign tq  = r_tp[63:30];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            // A: cos1*cos2 and sin^2(dlat/2)
            r_c12p    <= 66'(r_cs1) * 66'(r_cs2);
            r_ma_sq   <= 66'(r_slat) * 66'(r_slat);
            r_ma_slon <= r_slon;
            // B: (cos1*cos2 >> 30) * sin(dlon/2)
            r_tp      <= 67'(c12) * 67'(r_ma_slon);
            r_mb_sq   <= r_ma_sq;
            r_mb_slon <= r_ma_slon;
            // C: (t >> 30) * sin(dlon/2)
            r_ts      <= 67'(tq) * 67'(r_mb_slon);
            r_mc_sq   <= r_mb_sq;
        end
    end

    // ---------------- h = sum, clamped to [0, 1] in Q60 ----------------
    logic signed [67:0] h_sum;
    logic [60:0]        h_cl;
    logic [60:0]        r_hs, r_hc;

    assign h_sum = 68'(r_mc_sq) + 68'(r_ts);

    always_comb begin
        if (h_sum < 0) begin
            h_cl = '0;
        end else if (h_sum > $signed(68'(Q60_ONE))) begin
            h_cl = Q60_ONE;
        end else begin
            h_cl = h_sum[60:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_hs <= h_cl;
            r_hc <= Q60_ONE - h_cl;
        end
    end

    // ---------------- bitwise square roots, one result bit per stage ----------
    // lane 0: sqrt(h), lane 1: sqrt(1-h)
    logic [QW-1:0] r_qv [2][QN];
    logic [QW-1:0] r_qr [2][QN];

    genvar q, k;
    generate
        for (q = 0; q < 2; q++) begin : g_sq
            for (k = 0; k < QN; k++) begin : g_step
                localparam logic [QW-1:0] QB = QW'(1) << (60 - 2 * k);
                logic [QW-1:0] vi, ri, rb;
                if (k == 0) begin : g_first
                    assign vi = (q == 0) ? QW'(r_hs) : QW'(r_hc);
                    assign ri = '0;
                end else begin : g_next
                    assign vi = r_qv[q][k-1];
                    assign ri = r_qr[q][k-1];
                end
                assign rb = ri + QB;
                always_ff @(posedge i_clk) begin
                    if (ce) begin
                        if (vi >= rb) begin
                            r_qv[q][k] <= vi - rb;
                            r_qr[q][k] <= (ri >> 1) + QB;
                        end else begin
                            r_qv[q][k] <= vi;
                            r_qr[q][k] <= ri >> 1;
                        end
                    end
                end
            end
        end
    endgenerate

    // ---------------- vectoring CORDIC: atan2(sqrt(h), sqrt(1-h)) ----------
    logic signed [XW-1:0] r_vx [NS];
    logic signed [XW-1:0] r_vy [NS];
    logic signed [ZW-1:0] r_vz [NS];

    generate
        for (j = 0; j < NS; j++) begin : g_vec
            logic signed [XW-1:0] xi, yi, xs, ys;
            logic signed [ZW-1:0] zi, at;
            if (j == 0) begin : g_first
                assign xi = $signed({2'b00, r_qr[1][QN-1][30:0]});
                assign yi = $signed({2'b00, r_qr[0][QN-1][30:0]});
                assign zi = '0;
            end else begin : g_next
                assign xi = r_vx[j-1];
                assign yi = r_vy[j-1];
                assign zi = r_vz[j-1];
            end
            assign xs = xi >>> j;
            assign ys = yi >>> j;
            assign at = $signed({2'b00, ATAN_PHASE[j]});
            always_ff @(posedge i_clk) begin
                if (ce) begin
                    if (yi > 0) begin
                        r_vx[j] <= xi + ys;
                        r_vy[j] <= yi - xs;
                        r_vz[j] <= zi + at;
                    end else if (yi < 0) begin
                        r_vx[j] <= xi - ys;
                        r_vy[j] <= yi + xs;
                        r_vz[j] <= zi - at;
                    end else begin
                        // y already zero: no rotation
                        r_vx[j] <= xi;
                        r_vy[j] <= yi;
                        r_vz[j] <= zi;
                    end
                end
            end
        end
    endgenerate

    // ---------------- clamp angle, scale to cm ----------------
    logic [30:0] r_zc;
    logic [63:0] r_dp;
    logic [63:0] d_sum;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (r_vz[NS-1] < 0) begin
                r_zc <= '0;
            end else if (r_vz[NS-1] > $signed(ZW'(Q30_ONE))) begin
                r_zc <= Q30_ONE;
            end else begin
                r_zc <= r_vz[NS-1][30:0];
            end
            r_dp <= 64'(r_zc) * 64'(DIST_SCALE);
        end
    end

    assign d_sum  = r_dp + 64'h8000_0000;
    assign p_dist = (d_sum[63:32] > 32'(DIST_MAX)) ? DIST_MAX : d_sum[62:32];

    // ---------------- output register + skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_out_v && !i_m_axis_tready) begin
            if (ce && pv) begin
                r_sk_v <= 1'b1;
            end
        end else if (r_sk_v) begin
            r_out_v <= 1'b1;
            r_sk_v  <= 1'b0;
        end else begin
            r_out_v <= pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_v && !i_m_axis_tready) begin
            if (ce && pv) begin
                r_sk_d <= p_dist;
            end
        end else if (r_sk_v) begin
            r_out_d <= r_sk_d;
        end else begin
            r_out_d <= p_dist;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_d);

endmodule

`default_nettype wire

>>> rtl/hav_checker.sv
// Checker: port-level assertions for the haversine block, bound to the top level.
`default_nettype none

module hav_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_axis_tvalid,
    input wire logic                           o_s_axis_tready,
    input wire logic [hav_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    input wire logic                           o_m_axis_tvalid,
    input wire logic                           i_m_axis_tready,
    input wire logic [hav_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import hav_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed under stall");

    // distance never above half circumference, pad bit zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[30:0] <= DIST_MAX) && !o_m_axis_tdata[31])
        else $error("distance out of range");

    // input is only blocked with a result pending
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input blocked with empty output");

    // a taken result frees the input side next cycle
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready |=> o_s_axis_tready)
        else $error("skid not drained");

endmodule

bind haversine_distance hav_checker u_hav_checker (.*);

`default_nettype wire
